// ===== rtl/core/rbes_pkg.sv =====
// Shared types, constants and fixed-point helpers for the rigid body step block.
package rbes_pkg;

    // Input event codes
    localparam logic [2:0] K_TICK  = 3'd0;
    localparam logic [2:0] K_COLL  = 3'd1;
    localparam logic [2:0] K_FORCE = 3'd2;
    localparam logic [2:0] K_IMP   = 3'd3;
    localparam logic [2:0] K_ANG   = 3'd4;
    localparam logic [2:0] K_ZERO  = 3'd5;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);

    // Register reset values
    localparam logic [30:0] MASS_RST  = 31'd65536;
    localparam logic [30:0] GRAV_RST  = 31'd642253;
    localparam logic [30:0] MAXSP_RST = 31'd458752;
    localparam logic [16:0] REST_RST  = 17'd19661;
    localparam logic [16:0] GFRIC_RST = 17'd52429;
    localparam logic [16:0] ADAMP_RST = 17'd62259;
    localparam logic [16:0] SDAMP_RST = 17'd65536;

    localparam logic [17:0]        ONE_Q16   = 18'd65536;
    localparam logic signed [31:0] HALF_Q16  = 32'sd32768;
    localparam logic signed [32:0] ONE_Q30   = 33'sd1073741824;
    localparam logic [63:0]        SPIN_THR  = 64'd4294967;

    localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
    localparam logic signed [71:0] S32_MIN = -72'sd2147483648;

    typedef enum logic [2:0] {
        OP_TICK, OP_COLL, OP_FORCE, OP_IMP, OP_ANG, OP_ZERO
    } t_op;

    typedef enum logic [2:0] {
        CR_MASS, CR_GRAV, CR_MAXSP, CR_REST, CR_GFRIC, CR_ADAMP, CR_SDAMP, CR_ENABLE
    } t_creg;

    typedef struct packed {
        logic [30:0] mass;
        logic [30:0] grav;
        logic [30:0] max_speed;
        logic [16:0] restitution;
        logic [16:0] ground_friction;
        logic [16:0] air_damping;
        logic [16:0] spin_damping;
        logic        enabled;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic [16:0]      dt;
        logic [2:0][31:0] vec;
        logic [3:0][31:0] quat;
    } t_item;

    typedef enum logic {IOP_DIV, IOP_SQRT} t_iop;

    typedef struct packed {
        logic        start;
        t_iop        op;
        logic [63:0] num;
        logic [31:0] den;
        logic [63:0] rad;
    } t_ireq;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] root;
    } t_iresp;

    typedef enum logic [1:0] {I_IDLE, I_DIV, I_SQRT, I_FIN} t_ist;

    typedef enum logic [4:0] {
        B_IDLE, B_CNEG, B_CDOT, B_CP, B_CK, B_CGF, B_IMP,
        B_TGM, B_TACC, B_TVEL, B_TAIR, B_TL2, B_TLIM, B_TSQ, B_TCM, B_TCD,
        B_TPOS, B_TS2, B_TD, B_TR, B_TSH, B_TN2, B_TNS, B_TQN, B_TSD, B_TOUT
    } t_bst;

    // Hamilton product terms, component = step / 4 (x, y, z, w)
    // quaternion operand, delta operand (3 selects the unit w term), negate
    localparam logic [1:0] RT_Q [16] = '{
        2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2,
        2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] RT_D [16] = '{
        2'd0, 2'd3, 2'd2, 2'd1, 2'd1, 2'd2, 2'd3, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3, 2'd3, 2'd0, 2'd1, 2'd2};
    localparam logic RT_NEG [16] = '{
        1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        if (x > S32_MAX) begin
            return 32'sh7fffffff;
        end else if (x < S32_MIN) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [71:0] sx32(input logic signed [31:0] x);
        return {{40{x[31]}}, x};
    endfunction

    // Arithmetic right shift rounding toward zero
    function automatic logic signed [71:0] tz_shr(input logic signed [71:0] x,
                                                  input logic [4:0] sh);
        logic signed [71:0] bias;
        bias = x[71] ? ((72'sd1 <<< sh) - 72'sd1) : 72'sd0;
        return (x + bias) >>> sh;
    endfunction

endpackage

// ===== rtl/core/rigid_body_euler_step.sv =====
// Top level: configuration registers, front queue, back sequencer and shared iterative unit.
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_stall    | kind, delta_time, vec_x..z, quat_x..w
//  output  | out       | o_out_valid / i_out_stall  | new_pos_x..z, new_quat_x..w, rotation_changed
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index (3 bit), i_cfg_data (32 bit)
//
// Force, angular impulse and zero events finish in the idle state of the back end; collisions
// use only the multiplier. Impulses and ticks use divides, and ticks add a square root and divides
// when the speed limit applies and also when the body rotates: each divide and square root
// runs one bit per cycle on the single shared iterative unit.
// Reset restores the register defaults and clears the body state and the queue.
// The two-entry queue keeps taking items, until it is full, while the back end works or the output stalls.
module rigid_body_euler_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_kind,
    input  logic [16:0]        i_delta_time,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic signed [31:0] i_quat_x,
    input  logic signed [31:0] i_quat_y,
    input  logic signed [31:0] i_quat_z,
    input  logic signed [31:0] i_quat_w,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_new_pos_x,
    output logic signed [31:0] o_new_pos_y,
    output logic signed [31:0] o_new_pos_z,
    output logic signed [31:0] o_new_quat_x,
    output logic signed [31:0] o_new_quat_y,
    output logic signed [31:0] o_new_quat_z,
    output logic signed [31:0] o_new_quat_w,
    output logic               o_rotation_changed
);
    import rbes_pkg::*;

    t_cfg   r_cfg;
    t_item  w_item;
    logic   w_item_valid, w_pop;
    t_ireq  w_ireq;
    t_iresp w_iresp;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mass            <= MASS_RST;
            r_cfg.grav            <= GRAV_RST;
            r_cfg.max_speed       <= MAXSP_RST;
            r_cfg.restitution     <= REST_RST;
            r_cfg.ground_friction <= GFRIC_RST;
            r_cfg.air_damping     <= ADAMP_RST;
            r_cfg.spin_damping    <= SDAMP_RST;
            r_cfg.enabled         <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (t_creg'(i_cfg_index))
                CR_MASS:   r_cfg.mass            <= i_cfg_data[30:0];
                CR_GRAV:   r_cfg.grav            <= i_cfg_data[30:0];
                CR_MAXSP:  r_cfg.max_speed       <= i_cfg_data[30:0];
                CR_REST:   r_cfg.restitution     <= i_cfg_data[16:0];
                CR_GFRIC:  r_cfg.ground_friction <= i_cfg_data[16:0];
                CR_ADAMP:  r_cfg.air_damping     <= i_cfg_data[16:0];
                CR_SDAMP:  r_cfg.spin_damping    <= i_cfg_data[16:0];
                CR_ENABLE: r_cfg.enabled         <= i_cfg_data[0];
            endcase
        end
    end

    rbes_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_delta_time (i_delta_time),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_vec_z      (i_vec_z),
        .i_quat_x     (i_quat_x),
        .i_quat_y     (i_quat_y),
        .i_quat_z     (i_quat_z),
        .i_quat_w     (i_quat_w),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    rbes_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ireq),
        .o_resp  (w_iresp)
    );

    rbes_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_item_valid       (w_item_valid),
        .i_item             (w_item),
        .o_pop              (w_pop),
        .o_ireq             (w_ireq),
        .i_iresp            (w_iresp),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_new_pos_x        (o_new_pos_x),
        .o_new_pos_y        (o_new_pos_y),
        .o_new_pos_z        (o_new_pos_z),
        .o_new_quat_x       (o_new_quat_x),
        .o_new_quat_y       (o_new_quat_y),
        .o_new_quat_z       (o_new_quat_z),
        .o_new_quat_w       (o_new_quat_w),
        .o_rotation_changed (o_rotation_changed)
    );

endmodule

// ===== rtl/core/rbes_front.sv =====
// Front end: accepts items, drops no-op events and queues the rest for the back end.
module rbes_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbes_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_kind,
    input  logic [16:0]        i_delta_time,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic signed [31:0] i_quat_x,
    input  logic signed [31:0] i_quat_y,
    input  logic signed [31:0] i_quat_z,
    input  logic signed [31:0] i_quat_w,
    output logic               o_item_valid,
    output rbes_pkg::t_item    o_item,
    input  logic               i_pop
);
    import rbes_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QPW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [QPW:0]   r_cnt, n_cnt;
    t_item          w_item;
    logic           w_keep, w_push, w_pop;

    // Classify the event
    always_comb begin
        w_item.dt   = i_delta_time;
        w_item.vec  = {i_vec_z, i_vec_y, i_vec_x};
        w_item.quat = {i_quat_w, i_quat_z, i_quat_y, i_quat_x};
        w_item.op   = OP_TICK;
        w_keep      = 1'b1;
        unique case (i_kind)
            K_TICK:  begin w_item.op = OP_TICK; w_keep = i_cfg.enabled; end
            K_COLL:  w_item.op = OP_COLL;
            K_FORCE: w_item.op = OP_FORCE;
            K_IMP:   w_item.op = OP_IMP;
            K_ANG:   w_item.op = OP_ANG;
            K_ZERO:  w_item.op = OP_ZERO;
            default: w_keep = 1'b0;
        endcase
    end

    assign o_in_stall   = (r_cnt == (QPW+1)'(QDEPTH));
    assign w_push       = i_in_valid && !o_in_stall && w_keep;
    assign w_pop        = i_pop && (r_cnt != '0);
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rp];

    // Queue pointers
    always_comb begin
        n_wp  = w_push ? QPW'(r_wp + 1'b1) : r_wp;
        n_rp  = w_pop ? QPW'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt + (QPW+1)'(w_push) - (QPW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

endmodule

// ===== rtl/core/rbes_iter.sv =====
// Shared iterative unit: signed-by-unsigned divide (one quotient bit per cycle) and integer sqrt.
module rbes_iter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rbes_pkg::t_ireq  i_req,
    output rbes_pkg::t_iresp o_resp
);
    import rbes_pkg::*;

    t_ist        r_st, n_st;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_num, n_num;
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_bit, n_bit;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic [32:0] w_rs;
    logic [63:0] w_trial;
    logic [31:0] w_mlo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= I_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_quo <= n_quo;
        r_bit <= n_bit;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    always_comb begin
        n_st    = r_st;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_quo   = r_quo;
        n_bit   = r_bit;
        n_rem   = r_rem;
        n_den   = r_den;
        n_neg   = r_neg;
        w_rs    = {r_rem[31:0], r_num[63]};
        w_trial = r_quo + r_bit;
        w_mlo   = r_quo[31:0];

        // Saturated signed quotient
        o_resp.done = 1'b0;
        o_resp.root = r_quo[31:0];
        if (!r_neg) begin
            o_resp.quo = (r_quo > 64'd2147483647) ? 32'h7fffffff : w_mlo;
        end else begin
            o_resp.quo = (r_quo > 64'd2147483648) ? 32'h80000000 : 32'(32'd0 - w_mlo);
        end

        unique case (r_st)
            I_IDLE: begin
                n_cnt = '0;
                if (i_req.start) begin
                    if (i_req.op == IOP_DIV) begin
                        n_neg = i_req.num[63];
                        n_num = i_req.num[63] ? 64'(64'd0 - i_req.num) : i_req.num;
                        n_den = i_req.den;
                        n_rem = '0;
                        n_quo = '0;
                        n_st  = I_DIV;
                    end else begin
                        n_neg = 1'b0;
                        n_num = i_req.rad;
                        n_quo = '0;
                        n_bit = 64'h4000_0000_0000_0000;
                        n_st  = I_SQRT;
                    end
                end
            end
            I_DIV: begin
                // restoring step
                if (w_rs >= {1'b0, r_den}) begin
                    n_rem = w_rs - {1'b0, r_den};
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = w_rs;
                    n_quo = {r_quo[62:0], 1'b0};
                end
                n_num = {r_num[62:0], 1'b0};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_st = I_FIN;
                end
            end
            I_SQRT: begin
                if (r_num >= w_trial) begin
                    n_num = r_num - w_trial;
                    n_quo = (r_quo >> 1) + r_bit;
                end else begin
                    n_quo = r_quo >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    n_st = I_FIN;
                end
            end
            I_FIN: begin
                o_resp.done = 1'b1;
                n_st        = I_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/rbes_back.sv =====
// Back end: body state and the step sequencer around one shared multiplier and the iterative unit.
module rbes_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbes_pkg::t_cfg     i_cfg,
    input  logic               i_item_valid,
    input  rbes_pkg::t_item    i_item,
    output logic               o_pop,
    output rbes_pkg::t_ireq    o_ireq,
    input  rbes_pkg::t_iresp   i_iresp,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_new_pos_x,
    output logic signed [31:0] o_new_pos_y,
    output logic signed [31:0] o_new_pos_z,
    output logic signed [31:0] o_new_quat_x,
    output logic signed [31:0] o_new_quat_y,
    output logic signed [31:0] o_new_quat_z,
    output logic signed [31:0] o_new_quat_w,
    output logic               o_rotation_changed
);
    import rbes_pkg::*;

    t_bst               r_st, n_st;
    logic               r_ph, n_ph;
    logic [3:0]         r_idx, n_idx;
    logic signed [31:0] r_vel [3], n_vel [3];
    logic signed [31:0] r_frc [3], n_frc [3];
    logic signed [31:0] r_spin [3], n_spin [3];
    logic               r_gnd, n_gnd;
    logic               r_ovalid, n_ovalid;

    logic [16:0]        r_dt, n_dt;
    logic signed [31:0] r_vec [3], n_vec [3];
    logic signed [31:0] r_q [4], n_q [4];
    logic signed [31:0] r_d [3], n_d [3];
    logic signed [35:0] r_r [4], n_r [4];
    logic signed [31:0] r_acc, n_acc;
    logic signed [31:0] r_dq, n_dq;
    logic signed [49:0] r_dot, n_dot;
    logic [63:0]        r_acc64, n_acc64;
    logic [31:0]        r_norm, n_norm;
    logic               r_chg, n_chg;
    logic signed [31:0] r_opos [3], n_opos [3];
    logic signed [31:0] r_oq [4], n_oq [4];
    logic               r_ochg, n_ochg;

    logic signed [32:0] m_a, m_b;
    logic signed [65:0] r_prod;
    logic               m_use;
    logic [1:0]         iv;
    logic [31:0]        w_mden;

    logic signed [71:0] pw;
    logic signed [31:0] q16;
    logic signed [49:0] dsum;
    logic [63:0]        s64;
    logic signed [35:0] term;
    logic               big;

    assign iv     = r_idx[1:0];
    assign w_mden = (i_cfg.mass == '0) ? 32'd1 : {1'b0, i_cfg.mass};

    // Multiplier operand select
    always_comb begin
        m_a   = '0;
        m_b   = '0;
        m_use = 1'b1;
        unique case (r_st)
            B_CDOT: begin m_a = {r_vel[iv][31], r_vel[iv]}; m_b = {r_vec[iv][31], r_vec[iv]}; end
            B_CP:   begin m_a = {r_vec[iv][31], r_vec[iv]}; m_b = {r_dq[31], r_dq}; end
            B_CK: begin
                m_a = {r_acc[31], r_acc};
                m_b = {15'd0, 18'({1'b0, i_cfg.restitution} + ONE_Q16)};
            end
            B_CGF:  begin m_a = {r_vel[iv][31], r_vel[iv]}; m_b = {16'd0, i_cfg.ground_friction}; end
            B_TGM:  begin m_a = {2'b0, i_cfg.grav}; m_b = {2'b0, i_cfg.mass}; end
            B_TVEL: begin m_a = {r_acc[31], r_acc}; m_b = {16'd0, r_dt}; end
            B_TAIR: begin m_a = {r_vel[iv][31], r_vel[iv]}; m_b = {16'd0, i_cfg.air_damping}; end
            B_TL2:  begin m_a = {r_vel[iv][31], r_vel[iv]}; m_b = {r_vel[iv][31], r_vel[iv]}; end
            B_TLIM: begin m_a = {2'b0, i_cfg.max_speed}; m_b = {2'b0, i_cfg.max_speed}; end
            B_TCM:  begin m_a = {r_vel[iv][31], r_vel[iv]}; m_b = {2'b0, i_cfg.max_speed}; end
            B_TPOS: begin m_a = {r_vel[iv][31], r_vel[iv]}; m_b = {16'd0, r_dt}; end
            B_TS2:  begin m_a = {r_spin[iv][31], r_spin[iv]}; m_b = {r_spin[iv][31], r_spin[iv]}; end
            B_TD:   begin m_a = {r_spin[iv][31], r_spin[iv]}; m_b = {16'd0, r_dt}; end
            B_TR: begin
                m_a = {r_q[RT_Q[r_idx]][31], r_q[RT_Q[r_idx]]};
                m_b = (RT_D[r_idx] == 2'd3) ? ONE_Q30 :
                      {r_d[RT_D[r_idx]][31], r_d[RT_D[r_idx]]};
            end
            B_TN2:  begin m_a = {r_r[iv][31], r_r[iv][31:0]}; m_b = {r_r[iv][31], r_r[iv][31:0]}; end
            B_TSD:  begin m_a = {r_spin[iv][31], r_spin[iv]}; m_b = {16'd0, i_cfg.spin_damping}; end
            default: m_use = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_use && !r_ph) begin
            r_prod <= m_a * m_b;
        end
    end

    // Sequencer
    always_comb begin
        n_st = r_st;   n_ph = r_ph;   n_idx = r_idx;
        n_vel = r_vel; n_frc = r_frc; n_spin = r_spin; n_gnd = r_gnd;
        n_dt = r_dt;   n_vec = r_vec; n_q = r_q;       n_d = r_d;   n_r = r_r;
        n_acc = r_acc; n_dq = r_dq;   n_dot = r_dot;   n_acc64 = r_acc64;
        n_norm = r_norm; n_chg = r_chg;
        n_opos = r_opos; n_oq = r_oq; n_ochg = r_ochg;
        n_ovalid = r_ovalid && i_out_stall;
        o_pop    = 1'b0;
        o_ireq   = '0;
        o_ireq.op  = IOP_DIV;
        o_ireq.den = w_mden;

        pw   = {{6{r_prod[65]}}, r_prod};
        q16  = sat32(tz_shr(pw, 5'd16));
        dsum = r_dot + 50'(tz_shr(pw, 5'd16));
        s64  = ((r_idx == 4'd0) ? 64'd0 : r_acc64) + r_prod[63:0];
        term = 36'(tz_shr(pw, 5'd30));
        big  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (r_r[i] >= 36'sd2147483648 || r_r[i] <= -36'sd2147483648) begin
                big = 1'b1;
            end
        end

        unique case (r_st)
            B_IDLE: begin
                n_ph  = 1'b0;
                n_idx = '0;
                if (i_item_valid) begin
                    o_pop = 1'b1;
                    n_dt  = i_item.dt;
                    for (int i = 0; i < 3; i++) n_vec[i] = $signed(i_item.vec[i]);
                    for (int i = 0; i < 4; i++) n_q[i] = $signed(i_item.quat[i]);
                    n_dot = '0;
                    n_chg = 1'b0;
                    unique case (i_item.op)
                        OP_TICK: n_st = B_TGM;
                        OP_COLL: n_st = B_CNEG;
                        OP_IMP:  n_st = B_IMP;
                        OP_FORCE: begin
                            for (int i = 0; i < 3; i++)
                                n_frc[i] = sat32(sx32(r_frc[i]) + sx32($signed(i_item.vec[i])));
                        end
                        OP_ANG: begin
                            for (int i = 0; i < 3; i++)
                                n_spin[i] = sat32(sx32(r_spin[i]) + sx32($signed(i_item.vec[i])));
                        end
                        OP_ZERO: begin
                            for (int i = 0; i < 3; i++) begin
                                n_vel[i]  = '0;
                                n_spin[i] = '0;
                            end
                        end
                    endcase
                end
            end

            // Collision: negate normal, dot, reflect, floor friction
            B_CNEG: begin
                for (int i = 0; i < 3; i++) n_vec[i] = sat32(-sx32(r_vec[i]));
                n_st = B_CDOT;
            end
            B_CDOT: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_dot = dsum;
                    if (r_idx == 4'd2) begin
                        n_idx = '0;
                        n_dq  = sat32({{22{dsum[49]}}, dsum});
                        n_st  = dsum[49] ? B_CP : B_IDLE;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            B_CP: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_acc = q16;
                    n_st  = B_CK;
                end
            end
            B_CK: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_vel[iv] = sat32(sx32(r_vel[iv]) - tz_shr(pw, 5'd16));
                    if (r_idx == 4'd2) begin
                        n_idx = '0;
                        if (r_vec[1] > HALF_Q16) begin
                            n_gnd = 1'b1;
                            n_st  = B_CGF;
                        end else begin
                            n_st = B_IDLE;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                        n_st  = B_CP;
                    end
                end
            end
            B_CGF: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_vel[iv] = q16;
                    if (r_idx == 4'd0) n_idx = 4'd2;
                    else n_st = B_IDLE;
                end
            end

            // Impulse: velocity += impulse / mass
            B_IMP: begin
                if (!r_ph) begin
                    o_ireq.start = 1'b1;
                    o_ireq.num   = {{16{r_vec[iv][31]}}, r_vec[iv], 16'd0};
                    n_ph = 1'b1;
                end else if (i_iresp.done) begin
                    n_ph = 1'b0;
                    n_vel[iv] = sat32(sx32(r_vel[iv]) + sx32($signed(i_iresp.quo)));
                    if (r_idx == 4'd2) n_st = B_IDLE;
                    else n_idx = r_idx + 4'd1;
                end
            end

            // Tick: gravity, acceleration, velocity, air damping when not on the ground
            B_TGM: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_frc[1] = sat32(sx32(r_frc[1]) - sx32(q16));
                    n_idx    = '0;
                    n_st     = B_TACC;
                end
            end
            B_TACC: begin
                if (!r_ph) begin
                    o_ireq.start = 1'b1;
                    o_ireq.num   = {{16{r_frc[iv][31]}}, r_frc[iv], 16'd0};
                    n_ph = 1'b1;
                end else if (i_iresp.done) begin
                    n_ph  = 1'b0;
                    n_acc = $signed(i_iresp.quo);
                    n_st  = B_TVEL;
                end
            end
            B_TVEL: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_vel[iv] = sat32(sx32(r_vel[iv]) + sx32(q16));
                    if (r_idx == 4'd2) begin
                        n_idx = '0;
                        n_st  = r_gnd ? B_TL2 : B_TAIR;
                    end else begin
                        n_idx = r_idx + 4'd1;
                        n_st  = B_TACC;
                    end
                end
            end
            B_TAIR: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_vel[iv] = q16;
                    if (r_idx == 4'd0) begin
                        n_idx = 4'd2;
                    end else begin
                        n_idx = '0;
                        n_st  = B_TL2;
                    end
                end
            end

            // Horizontal speed limit
            B_TL2: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_acc64 = s64;
                    if (r_idx == 4'd0) n_idx = 4'd2;
                    else n_st = B_TLIM;
                end
            end
            B_TLIM: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_idx = '0;
                    n_st  = (r_acc64 > r_prod[63:0]) ? B_TSQ : B_TPOS;
                end
            end
            B_TSQ: begin
                o_ireq.op  = IOP_SQRT;
                o_ireq.rad = r_acc64;
                if (!r_ph) begin
                    o_ireq.start = 1'b1;
                    n_ph = 1'b1;
                end else if (i_iresp.done) begin
                    n_ph   = 1'b0;
                    n_norm = i_iresp.root;
                    n_st   = B_TCM;
                end
            end
            B_TCM: begin
                n_ph = !r_ph;
                if (r_ph) n_st = B_TCD;
            end
            B_TCD: begin
                o_ireq.num = r_prod[63:0];
                o_ireq.den = r_norm;
                if (!r_ph) begin
                    o_ireq.start = 1'b1;
                    n_ph = 1'b1;
                end else if (i_iresp.done) begin
                    n_ph      = 1'b0;
                    n_vel[iv] = $signed(i_iresp.quo);
                    if (r_idx == 4'd0) begin
                        n_idx = 4'd2;
                        n_st  = B_TCM;
                    end else begin
                        n_idx = '0;
                        n_st  = B_TPOS;
                    end
                end
            end

            // Position update, force clear
            B_TPOS: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_vec[iv] = sat32(sx32(r_vec[iv]) + sx32(q16));
                    if (r_idx == 4'd2) begin
                        for (int i = 0; i < 3; i++) n_frc[i] = '0;
                        n_idx = '0;
                        n_st  = B_TS2;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end

            // Spin test, small-angle rotation, normalisation and spin damping
            B_TS2: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_acc64 = s64;
                    if (r_idx == 4'd2) begin
                        n_idx = '0;
                        n_st  = (s64 > SPIN_THR) ? B_TD : B_TOUT;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            B_TD: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_d[iv] = sat32(tz_shr(pw, 5'd3));
                    if (r_idx == 4'd2) begin
                        n_idx = '0;
                        n_st  = B_TR;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            B_TR: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_r[r_idx[3:2]] = ((r_idx[1:0] == 2'd0) ? 36'sd0 : r_r[r_idx[3:2]])
                                    + (RT_NEG[r_idx] ? -term : term);
                    n_idx = r_idx + 4'd1;
                    if (r_idx == 4'd15) n_st = B_TSH;
                end
            end
            B_TSH: begin
                n_idx = '0;
                if (big) begin
                    for (int i = 0; i < 4; i++)
                        n_r[i] = (r_r[i] + (r_r[i][35] ? 36'sd1 : 36'sd0)) >>> 1;
                end else begin
                    n_st = B_TN2;
                end
            end
            B_TN2: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_acc64 = s64;
                    n_idx   = r_idx + 4'd1;
                    if (r_idx == 4'd3) n_st = B_TNS;
                end
            end
            B_TNS: begin
                o_ireq.op  = IOP_SQRT;
                o_ireq.rad = r_acc64;
                n_idx      = '0;
                if (!r_ph) begin
                    o_ireq.start = 1'b1;
                    n_ph = 1'b1;
                end else if (i_iresp.done) begin
                    n_ph   = 1'b0;
                    n_norm = i_iresp.root;
                    n_st   = B_TQN;
                end
            end
            B_TQN: begin
                o_ireq.num = {{2{r_r[iv][31]}}, r_r[iv][31:0], 30'd0};
                o_ireq.den = r_norm;
                if (r_norm == '0) begin
                    n_q[iv] = '0;
                    n_idx   = r_idx + 4'd1;
                    if (r_idx == 4'd3) begin
                        n_idx = '0;
                        n_st  = B_TSD;
                    end
                end else if (!r_ph) begin
                    o_ireq.start = 1'b1;
                    n_ph = 1'b1;
                end else if (i_iresp.done) begin
                    n_ph    = 1'b0;
                    n_q[iv] = $signed(i_iresp.quo);
                    n_idx   = r_idx + 4'd1;
                    if (r_idx == 4'd3) begin
                        n_idx = '0;
                        n_st  = B_TSD;
                    end
                end
            end
            B_TSD: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_spin[iv] = q16;
                    n_chg      = 1'b1;
                    if (r_idx == 4'd2) n_st = B_TOUT;
                    else n_idx = r_idx + 4'd1;
                end
            end

            // Hand the result to the output register
            B_TOUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_opos   = r_vec;
                    n_oq     = r_q;
                    n_ochg   = r_chg;
                    n_ovalid = 1'b1;
                    n_gnd    = 1'b0;
                    n_st     = B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= B_IDLE;
            r_ph     <= 1'b0;
            r_idx    <= '0;
            r_vel    <= '{default: '0};
            r_frc    <= '{default: '0};
            r_spin   <= '{default: '0};
            r_gnd    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_ph     <= n_ph;
            r_idx    <= n_idx;
            r_vel    <= n_vel;
            r_frc    <= n_frc;
            r_spin   <= n_spin;
            r_gnd    <= n_gnd;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dt    <= n_dt;
        r_vec   <= n_vec;
        r_q     <= n_q;
        r_d     <= n_d;
        r_r     <= n_r;
        r_acc   <= n_acc;
        r_dq    <= n_dq;
        r_dot   <= n_dot;
        r_acc64 <= n_acc64;
        r_norm  <= n_norm;
        r_chg   <= n_chg;
        r_opos  <= n_opos;
        r_oq    <= n_oq;
        r_ochg  <= n_ochg;
    end

    assign o_out_valid        = r_ovalid;
    assign o_new_pos_x        = r_opos[0];
    assign o_new_pos_y        = r_opos[1];
    assign o_new_pos_z        = r_opos[2];
    assign o_new_quat_x       = r_oq[0];
    assign o_new_quat_y       = r_oq[1];
    assign o_new_quat_z       = r_oq[2];
    assign o_new_quat_w       = r_oq[3];
    assign o_rotation_changed = r_ochg;

endmodule
